// ----- hw/rtl/dam_pkg.sv -----
`default_nettype none
package dam_pkg;
   localparam int WORD_W = 15;
   localparam int ADDR_W = 7;
   localparam int WORD_MAX = 9999;
   localparam logic [6:0] OP_READ = 7'd10;
   localparam logic [6:0] OP_WRITE = 7'd11;
   localparam logic [6:0] OP_LOAD = 7'd20;
   localparam logic [6:0] OP_STORE = 7'd21;
   localparam logic [6:0] OP_ADD = 7'd30;
   localparam logic [6:0] OP_SUB = 7'd31;
   localparam logic [6:0] OP_DIV = 7'd32;
   localparam logic [6:0] OP_MUL = 7'd33;
   localparam logic [6:0] OP_BR = 7'd40;
   localparam logic [6:0] OP_BRNEG = 7'd41;
   localparam logic [6:0] OP_BRZERO = 7'd42;
   localparam logic [6:0] OP_HALT = 7'd43;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_WORD = 2'd1;
   localparam logic [1:0] ST_HALT = 2'd2;
   localparam logic [1:0] ST_DIVZ = 2'd3;
   typedef struct packed {
      logic cmd;
      logic [ADDR_W-1:0] load_addr;
      logic signed [WORD_W-1:0] data_word;
   } item_type;
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [31:0] v);
      if (v > WORD_MAX) return WORD_W'(WORD_MAX);
      if (v < -WORD_MAX) return WORD_W'(-WORD_MAX);
      return v[WORD_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/decimal_accumulator_machine_core.sv -----
`default_nettype none
// decimal accumulator machine: MEM_WORDS signed decimal words, an accumulator and
// a program counter.
// input: an item is transferred when start is high and busy is low. req_cmd 0
// writes req_data_word (saturated to +-9999) at req_load_addr if under MEM_WORDS;
// req_cmd 1 runs the program counter's instruction, req_data_word feeding READ.
// output: one result per item, held on rsp_* for one cycle with rsp_strobe.
// the receiver cannot stall; results leave in order of transfer.
// a front queue takes the item, the back end runs it; busy drops in the cycle
// after the result has been sent, so one item is in the machine at a time.
// a load item goes straight to its result; an instruction's result waits on
// two registered memory reads, instruction then operand; a divide also waits
// on the bit-serial divider, which runs 14 steps, and a multiply on a product
// register.
// reset: memory is cleared by a pass over all MEM_WORDS words; items wait in the
// queue meanwhile. accumulator and program counter reset to zero.
module decimal_accumulator_machine_core #(parameter int MEM_WORDS = 100) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic req_cmd,
   input  wire logic [6:0] req_load_addr,
   input  wire logic signed [14:0] req_data_word,
   output logic rsp_strobe,
   output logic [1:0] rsp_status,
   output logic signed [14:0] rsp_out_word,
   output logic signed [14:0] rsp_acc_value,
   output logic [6:0] rsp_pc_value
);
   import dam_pkg::*;
   logic q_valid, q_take, back_idle;
   item_type q_item;
   dam_front u_front (.clock, .reset, .start, .req_cmd, .req_load_addr,
      .req_data_word, .busy, .q_valid, .q_item, .q_take, .back_idle);
   dam_back #(.MEM_WORDS(MEM_WORDS)) u_back (.clock, .reset, .q_valid, .q_item,
      .q_take, .idle(back_idle), .rsp_strobe, .rsp_status, .rsp_out_word,
      .rsp_acc_value, .rsp_pc_value);
endmodule
`default_nettype wire

// ----- hw/rtl/dam_front.sv -----
`default_nettype none
module dam_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic req_cmd,
   input  wire logic [6:0] req_load_addr,
   input  wire logic signed [14:0] req_data_word,
   output logic busy,
   output logic q_valid,
   output dam_pkg::item_type q_item,
   input  wire logic q_take,
   input  wire logic back_idle
);
   import dam_pkg::*;
   // two-entry queue; one item in the machine at a time keeps order trivial
   item_type slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, wr_ff;
   logic push;
   logic inflight_ff, inflight_in;
   assign busy = inflight_ff;
   assign push = start && !busy;
   assign q_valid = cnt_ff != 2'd0;
   assign q_item = slot_ff[rd_ff];
   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_take);
      inflight_in = inflight_ff;
      if (push) inflight_in = 1'b1;
      else if (inflight_ff && cnt_ff == 2'd0 && !q_take && back_idle) inflight_in = 1'b0;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0; rd_ff <= 1'b0; wr_ff <= 1'b0; inflight_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; inflight_ff <= inflight_in;
         if (push) wr_ff <= !wr_ff;
         if (q_take) rd_ff <= !rd_ff;
      end
      if (push) slot_ff[wr_ff] <= '{req_cmd, req_load_addr, sat_word(32'(req_data_word))};
   end
endmodule
`default_nettype wire

// ----- hw/rtl/dam_div.sv -----
`default_nettype none
module dam_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic go,
   input  wire logic signed [14:0] num,
   input  wire logic signed [14:0] den,
   output logic done,
   output logic signed [14:0] quo
);
   // restoring divide on magnitudes, one bit per cycle
   logic [13:0] q_ff, d_ff;
   logic [14:0] r_ff;
   logic [3:0] n_ff;
   logic neg_ff, run_ff;
   logic [14:0] trial;
   logic [13:0] an, ad;
   assign an = num[14] ? 14'(-num) : num[13:0];
   assign ad = den[14] ? 14'(-den) : den[13:0];
   assign trial = {r_ff[13:0], q_ff[13]};
   assign done = run_ff && n_ff == 4'd0;
   assign quo = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; n_ff <= 4'd0;
      end else if (go) begin
         run_ff <= 1'b1; n_ff <= 4'd14;
         q_ff <= an; d_ff <= ad; r_ff <= '0; neg_ff <= num[14] ^ den[14];
      end else if (run_ff && n_ff != 4'd0) begin
         n_ff <= n_ff - 4'd1;
         if (trial >= {1'b0, d_ff}) begin
            r_ff <= trial - {1'b0, d_ff}; q_ff <= {q_ff[12:0], 1'b1};
         end else begin
            r_ff <= trial; q_ff <= {q_ff[12:0], 1'b0};
         end
      end else run_ff <= 1'b0;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/dam_back.sv -----
`default_nettype none
module dam_back #(parameter int MEM_WORDS = 100) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   input  dam_pkg::item_type q_item,
   output logic q_take,
   output logic idle,
   output logic rsp_strobe,
   output logic [1:0] rsp_status,
   output logic signed [14:0] rsp_out_word,
   output logic signed [14:0] rsp_acc_value,
   output logic [6:0] rsp_pc_value
);
   import dam_pkg::*;
   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_FETCH = 4'd2, S_WAITI = 4'd3,
      S_DEC = 4'd4, S_OPRD = 4'd5, S_WAITO = 4'd6, S_EXEC = 4'd7, S_DIV = 4'd8,
      S_MUL = 4'd9, S_DONE = 4'd10;
   logic signed [14:0] mem [MEM_WORDS];
   logic [3:0] st_ff;
   logic [AW-1:0] raddr, waddr, clr_ff;
   logic we, re;
   logic signed [14:0] wdata, rdata_ff;
   logic [AW-1:0] pc_ff, opaddr_ff;
   logic [6:0] op_ff;
   logic signed [14:0] acc_ff, mval_ff;
   logic signed [29:0] prod_ff;
   item_type it_ff;
   logic [1:0] status_ff;
   logic signed [14:0] rep_ff;
   logic [13:0] mag;
   logic [6:0] opc, opr;
   logic [26:0] opc_prod;
   logic [13:0] opc_x100;
   logic [AW-1:0] exec_pc;
   logic [3:0] exec_st;
   logic div_go, div_done;
   logic signed [14:0] div_q;
   dam_div u_div (.clock, .reset, .go(div_go), .num(acc_ff), .den(mval_ff),
      .done(div_done), .quo(div_q));
   assign mag = rdata_ff[14] ? 14'(-rdata_ff) : rdata_ff[13:0];
   // divide by 100 as a reciprocal multiply, exact for every word up to 9999
   assign opc_prod = {13'd0, mag} * 27'd5243;
   assign opc = 7'(opc_prod >> 19);
   assign opc_x100 = 14'(opc) * 14'd100;
   assign opr = 7'(mag - opc_x100);
   assign q_take = st_ff == S_IDLE && q_valid;
   assign idle = st_ff == S_IDLE;
   assign div_go = st_ff == S_EXEC && op_ff == OP_DIV && mval_ff != 0;
   function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
      return (32'(p) + 1 >= MEM_WORDS) ? '0 : AW'(32'(p) + 1);
   endfunction
   // operand below 100, so for a depth of ten or more at most nine multiples of the depth to remove
   function automatic logic [AW-1:0] wrap_addr(input logic [6:0] a);
      logic [6:0] r;
      r = a;
      for (int k = 1; k <= 9; k++)
         if (32'(a) >= k * MEM_WORDS) r = 7'(32'(a) - 32'(k * MEM_WORDS));
      return AW'(r);
   endfunction
   always_comb begin
      re = st_ff == S_FETCH || st_ff == S_OPRD;
      raddr = st_ff == S_FETCH ? pc_ff : opaddr_ff;
      we = 1'b0; waddr = clr_ff; wdata = '0;
      if (st_ff == S_CLR) we = 1'b1;
      else if (q_take && !q_item.cmd && 32'(q_item.load_addr) < MEM_WORDS) begin
         we = 1'b1; waddr = AW'(q_item.load_addr); wdata = q_item.data_word;
      end else if (st_ff == S_EXEC && (op_ff == OP_READ || op_ff == OP_STORE)) begin
         we = 1'b1; waddr = opaddr_ff;
         wdata = op_ff == OP_READ ? it_ff.data_word : acc_ff;
      end
   end
   always_comb begin
      exec_pc = inc(pc_ff);
      exec_st = S_DONE;
      case (op_ff)
         OP_DIV: if (mval_ff == 0) exec_pc = '0; else exec_st = S_DIV;
         OP_MUL: exec_st = S_MUL;
         OP_BR: exec_pc = opaddr_ff;
         OP_BRNEG: if (acc_ff < 0) exec_pc = opaddr_ff;
         OP_BRZERO: if (acc_ff == 0) exec_pc = opaddr_ff;
         OP_HALT: exec_pc = '0;
         default: ;
      endcase
   end
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end
   always_ff @(posedge clock) begin
      rsp_strobe <= !reset && st_ff == S_DONE;
      if (reset) begin
         st_ff <= S_CLR; clr_ff <= '0; pc_ff <= '0; acc_ff <= '0;
      end else begin
         unique case (st_ff)
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
               if (32'(clr_ff) == MEM_WORDS - 1) st_ff <= S_IDLE;
            end
            S_IDLE: if (q_valid) begin
               it_ff <= q_item; status_ff <= ST_OK; rep_ff <= '0;
               st_ff <= q_item.cmd ? S_FETCH : S_DONE;
            end
            S_FETCH: st_ff <= S_WAITI;
            S_WAITI: st_ff <= S_DEC;
            S_DEC: begin
               op_ff <= opc; opaddr_ff <= wrap_addr(opr); st_ff <= S_OPRD;
            end
            S_OPRD: st_ff <= S_WAITO;
            S_WAITO: begin mval_ff <= rdata_ff; st_ff <= S_EXEC; end
            S_EXEC: begin
               pc_ff <= exec_pc; st_ff <= exec_st;
               case (op_ff)
                  OP_WRITE: begin rep_ff <= mval_ff; status_ff <= ST_WORD; end
                  OP_LOAD: acc_ff <= mval_ff;
                  OP_ADD: acc_ff <= sat_word(32'(acc_ff) + 32'(mval_ff));
                  OP_SUB: acc_ff <= sat_word(32'(acc_ff) - 32'(mval_ff));
                  OP_DIV: if (mval_ff == 0) status_ff <= ST_DIVZ;
                  OP_MUL: prod_ff <= acc_ff * mval_ff;
                  OP_HALT: status_ff <= ST_HALT;
                  default: ;
               endcase
            end
            S_DIV: if (div_done) begin acc_ff <= div_q; st_ff <= S_DONE; end
            S_MUL: begin acc_ff <= sat_word(32'(prod_ff)); st_ff <= S_DONE; end
            S_DONE: begin
               rsp_status <= status_ff; rsp_out_word <= rep_ff;
               rsp_acc_value <= acc_ff; rsp_pc_value <= 7'(pc_ff); st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
